>>> hdl/gbst_pkg.sv
// ----------------------------------------------------------------------------
// gbst_pkg : shared types and constants of the go-back sequence tracker
// Request and result layouts, queue sizing, mode and kind codes.
// ----------------------------------------------------------------------------
package gbst_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int MAX_RESULTS = 32;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] SEQ_NO_QUEUE = 16'hFFFF;

	// request modes
	localparam logic [2:0] MODE_SEND  = 3'd0;
	localparam logic [2:0] MODE_DATA  = 3'd1;
	localparam logic [2:0] MODE_ACK   = 3'd2;
	localparam logic [2:0] MODE_ERR   = 3'd3;
	localparam logic [2:0] MODE_RESET = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_ASSIGNED = 3'd0;
	localparam logic [2:0] KIND_ACK      = 3'd1;
	localparam logic [2:0] KIND_RESEND   = 3'd2;
	localparam logic [2:0] KIND_RETX     = 3'd3;
	localparam logic [2:0] KIND_IGNORED  = 3'd4;
	localparam logic [2:0] KIND_DONE     = 3'd5;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] seq;
		logic [15:0] handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] seq_out;
		logic [15:0] handle_out;
		logic        in_order;
		logic        queue_full;
		logic [5:0]  removed_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] handle;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

endpackage

>>> hdl/go_back_sequence_tracker.sv
// ----------------------------------------------------------------------------
// go_back_sequence_tracker : go-back-N sequence and retransmit tracker
// Assigns send numbers, checks received order, and walks the retransmit queue.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (req: mode, seq, handle) is taken on a rising edge with start
//    high and busy low.
//  - Every result appears on rsp for exactly one cycle with rsp_valid high;
//    the receiver cannot stall, so no result is ever held back.
//  - Send, received data, reset and unused modes complete in the accept cycle:
//    their single result shows in the next cycle and busy stays low, so one of
//    these requests can be taken every cycle.
//  - Ack and error walk the queue in RAM from the head, one entry per cycle
//    through the registered read port. Busy stays high for the whole walk; an
//    error walk delivers one retransmit per cycle for each entry that it
//    re-emits, the last flagged with last.
//    The final result of a walk shows in the cycle busy falls.
//  - Reset (arst_n low) clears counters, pointers and the walk state at once;
//    the queue RAM needs no clearing, as only entries inside the fill count
//    are ever used.
// ----------------------------------------------------------------------------
module go_back_sequence_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gbst_pkg::req_t req,
	output logic           rsp_valid,
	output gbst_pkg::rsp_t rsp
);

	gbst_pkg::state_t state_q;
	gbst_pkg::req_t   req_q;
	gbst_pkg::rsp_t   rsp_q;
	gbst_pkg::rsp_t   rsp_d;
	gbst_pkg::entry_t pend_q;
	gbst_pkg::entry_t rd_entry;
	gbst_pkg::entry_t wr_entry;

	logic                     rsp_valid_q;
	logic                     rsp_fire;
	logic                     pend_valid_q;
	logic [15:0]              next_send_q;
	logic [15:0]              next_exp_q;
	logic [gbst_pkg::QW-1:0]  head_q;
	logic [gbst_pkg::CW-1:0]  count_q;
	logic [gbst_pkg::QW-1:0]  ptr_q;
	logic [gbst_pkg::QW-1:0]  ptr_inc;
	logic [gbst_pkg::CW-1:0]  idx_q;
	logic [gbst_pkg::CW:0]    wr_sum;
	logic [gbst_pkg::QW-1:0]  wr_idx;
	logic [gbst_pkg::QW-1:0]  raddr;
	logic                     accept;
	logic                     walking;
	logic                     queue_free;
	logic                     send_queued;
	logic                     qual;

	assign accept  = start && (state_q == gbst_pkg::ST_IDLE);
	assign walking = (state_q == gbst_pkg::ST_WALK);
	assign busy    = walking;

	// tail slot: head plus fill count, folded back into the ring
	assign wr_sum = (gbst_pkg::CW+1)'(head_q) + (gbst_pkg::CW+1)'(count_q);
	assign wr_idx = (wr_sum >= (gbst_pkg::CW+1)'(gbst_pkg::QUEUE_DEPTH))
		? gbst_pkg::QW'(wr_sum - (gbst_pkg::CW+1)'(gbst_pkg::QUEUE_DEPTH))
		: gbst_pkg::QW'(wr_sum);

	assign queue_free  = count_q < gbst_pkg::CW'(gbst_pkg::QUEUE_DEPTH);
	// the top number is handed out but never queued
	assign send_queued = accept && (req.mode == gbst_pkg::MODE_SEND) &&
		(next_send_q != gbst_pkg::SEQ_NO_QUEUE) && queue_free;

	assign ptr_inc = (ptr_q == gbst_pkg::QW'(gbst_pkg::QUEUE_DEPTH - 1))
		? '0 : ptr_q + gbst_pkg::QW'(1);

	// The entry read last cycle sits at ptr_q. It takes part while it lies
	// inside the queue and at or below the limit; an error walk is also capped.
	assign qual = (idx_q < count_q) && (rd_entry.seq <= req_q.seq) &&
		((req_q.mode == gbst_pkg::MODE_ACK) ||
		 (int'(idx_q) < gbst_pkg::MAX_RESULTS));

	// read the head on accept, then stream the next entry while the walk goes on
	assign raddr = walking ? (qual ? ptr_inc : ptr_q) : head_q;

	assign wr_entry.seq    = next_send_q;
	assign wr_entry.handle = req.handle;

	gbst_ram #(
		.WIDTH($bits(gbst_pkg::entry_t)),
		.DEPTH(gbst_pkg::QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (send_queued),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	// Result of this cycle. A retransmit is held in the pending
	// register so that the walk knows whether it is the last one.
	always_comb begin
		rsp_d    = '0;
		rsp_fire = 1'b0;
		if (accept) begin
			rsp_fire      = 1'b1;
			rsp_d.last    = 1'b1;
			rsp_d.seq_out = req.seq;
			unique case (req.mode)
				gbst_pkg::MODE_SEND: begin
					rsp_d.kind       = gbst_pkg::KIND_ASSIGNED;
					rsp_d.seq_out    = next_send_q;
					rsp_d.handle_out = req.handle;
					rsp_d.queue_full = (next_send_q != gbst_pkg::SEQ_NO_QUEUE) &&
						!queue_free;
				end
				gbst_pkg::MODE_DATA: begin
					priority if (req.seq == next_exp_q) begin
						rsp_d.kind     = gbst_pkg::KIND_ACK;
						rsp_d.in_order = 1'b1;
					end else if (req.seq > next_exp_q) begin
						rsp_d.kind    = gbst_pkg::KIND_RESEND;
						rsp_d.seq_out = next_exp_q - 16'd1;
					end else begin
						rsp_d.kind = gbst_pkg::KIND_IGNORED;
					end
				end
				gbst_pkg::MODE_ACK, gbst_pkg::MODE_ERR: begin
					rsp_fire = 1'b0;
				end
				gbst_pkg::MODE_RESET: begin
					rsp_d.kind = gbst_pkg::KIND_DONE;
				end
				default: begin
					rsp_d.kind = gbst_pkg::KIND_IGNORED;
				end
			endcase
		end else if (walking) begin
			rsp_d.seq_out = req_q.seq;
			if (req_q.mode == gbst_pkg::MODE_ACK) begin
				if (!qual) begin
					rsp_fire            = 1'b1;
					rsp_d.kind          = gbst_pkg::KIND_DONE;
					rsp_d.removed_count = 6'(idx_q);
					rsp_d.last          = 1'b1;
				end
			end else begin
				if (pend_valid_q) begin
					// release the held retransmit; last when the walk stops here
					rsp_fire         = 1'b1;
					rsp_d.kind       = gbst_pkg::KIND_RETX;
					rsp_d.seq_out    = pend_q.seq;
					rsp_d.handle_out = pend_q.handle;
					rsp_d.last       = !qual;
				end else if (!qual) begin
					rsp_fire   = 1'b1;
					rsp_d.kind = gbst_pkg::KIND_DONE;
					rsp_d.last = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gbst_pkg::ST_IDLE;
			next_send_q  <= '0;
			next_exp_q   <= '0;
			head_q       <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_fire;
			if (accept) begin
				unique case (req.mode)
					gbst_pkg::MODE_SEND: begin
						next_send_q <= next_send_q + 16'd1;
						if (send_queued) begin
							count_q <= count_q + gbst_pkg::CW'(1);
						end
					end
					gbst_pkg::MODE_DATA: begin
						if (req.seq == next_exp_q) begin
							next_exp_q <= next_exp_q + 16'd1;
						end
					end
					gbst_pkg::MODE_ACK: begin
						// an ack beyond what was sent moves the send number past it
						if (req.seq > next_send_q) begin
							next_send_q <= req.seq + 16'd1;
						end
						state_q <= gbst_pkg::ST_WALK;
						ptr_q   <= head_q;
						idx_q   <= '0;
					end
					gbst_pkg::MODE_ERR: begin
						state_q      <= gbst_pkg::ST_WALK;
						ptr_q        <= head_q;
						idx_q        <= '0;
						pend_valid_q <= 1'b0;
					end
					gbst_pkg::MODE_RESET: begin
						next_send_q <= '0;
						next_exp_q  <= '0;
						head_q      <= '0;
						count_q     <= '0;
					end
					default: begin
					end
				endcase
			end else if (walking) begin
				if (qual) begin
					ptr_q <= ptr_inc;
					idx_q <= idx_q + gbst_pkg::CW'(1);
					if (req_q.mode == gbst_pkg::MODE_ERR) begin
						pend_valid_q <= 1'b1;
					end
				end else begin
					state_q      <= gbst_pkg::ST_IDLE;
					pend_valid_q <= 1'b0;
					// an ack pops everything walked over; an error leaves the queue
					if (req_q.mode == gbst_pkg::MODE_ACK) begin
						head_q  <= ptr_q;
						count_q <= count_q - idx_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (accept) begin
			req_q <= req;
		end
		if (walking && qual) begin
			pend_q <= rd_entry;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the fill count never passes the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gbst_pkg::CW'(gbst_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	// a walk always ends with a final result in the cycle busy falls
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (rsp_valid && rsp.last))
		else $error("walk ended without a final result");

	// single-result requests answer in the cycle after the request
	a_single_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.mode != gbst_pkg::MODE_ACK) &&
		 (req.mode != gbst_pkg::MODE_ERR)) |=> (rsp_valid && rsp.last))
		else $error("missing single result");

	// a walk only ever runs for an ack or an error request
	a_walk_mode: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ((req_q.mode == gbst_pkg::MODE_ACK) ||
		          (req_q.mode == gbst_pkg::MODE_ERR)))
		else $error("walk running for a request that needs none");

endmodule

>>> hdl/gbst_ram.sv
// ----------------------------------------------------------------------------
// gbst_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
